// ----- rtl/clle_pkg.sv -----
// Shared types and codes for the cursor linked list engine.
package clle_pkg;

  // Operation codes carried on the request's user sideband
  typedef enum logic [3:0] {
    FN_QUERY      = 4'd0,
    FN_PREPEND    = 4'd1,
    FN_APPEND     = 4'd2,
    FN_INS_BEFORE = 4'd3,
    FN_INS_AFTER  = 4'd4,
    FN_DEL_FRONT  = 4'd5,
    FN_DEL_BACK   = 4'd6,
    FN_DEL_CURSOR = 4'd7,
    FN_SET        = 4'd8,
    FN_MV_FRONT   = 4'd9,
    FN_MV_BACK    = 4'd10,
    FN_MV_PREV    = 4'd11,
    FN_MV_NEXT    = 4'd12,
    FN_CLEAR      = 4'd13
  } func_t;

  // Result status codes
  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_EMPTY     = 2'd1,
    STAT_NO_CURSOR = 2'd2,
    STAT_FULL      = 2'd3
  } status_t;

  // Per-row command, broadcast to every cell of one row
  typedef struct packed {
    logic load;        // take the parallel load word
    logic rot_up;      // ring rotate: cell k takes cell k-1
    logic rot_down;    // ring rotate: cell k takes cell k+1
    logic wr_en;       // write the request word at wr_pos
    logic shift_up;    // cells in (lo, hi] take left neighbor
    logic shift_down;  // cells in [lo, hi) take right neighbor
  } row_ctl_t;

endpackage

// ----- rtl/clle_cell.sv -----
// One storage cell of a list row: holds one element word and trades with its neighbors.
module clle_cell #(
  parameter int DW  = 32,
  parameter int IW  = 8,
  parameter int IDX = 0
) (
  input  logic                clk,
  input  clle_pkg::row_ctl_t  ctl,
  input  logic [IW-1:0]       lo,
  input  logic [IW-1:0]       hi,
  input  logic [IW-1:0]       wr_pos,
  input  logic [DW-1:0]       wr_value,
  input  logic [DW-1:0]       load_value,
  input  logic [DW-1:0]       left_value,
  input  logic [DW-1:0]       right_value,
  output logic [DW-1:0]       value
);

  localparam logic [IW-1:0] Pos = IW'(IDX);

  logic [DW-1:0] value_next;

  // Pick the word this cell holds after the command
  always_comb begin
    priority if (ctl.load) begin
      value_next = load_value;
    end else if (ctl.rot_up) begin
      value_next = left_value;
    end else if (ctl.rot_down) begin
      value_next = right_value;
    end else if (ctl.wr_en && (Pos == wr_pos)) begin
      value_next = wr_value;
    end else if (ctl.shift_up && (Pos > lo) && (Pos <= hi)) begin
      value_next = left_value;
    end else if (ctl.shift_down && (Pos >= lo) && (Pos < hi)) begin
      value_next = right_value;
    end else begin
      value_next = value;
    end
  end

  always_ff @(posedge clk) begin
    value <= value_next;
  end

endmodule

// ----- rtl/clle_row.sv -----
// A ring of identical cells that inserts, deletes, writes, rotates or loads.
module clle_row #(
  parameter int DEPTH = 256,
  parameter int DW    = 32,
  parameter int IW    = 8
) (
  input  logic                clk,
  input  clle_pkg::row_ctl_t  ctl,
  input  logic [IW-1:0]       lo,
  input  logic [IW-1:0]       hi,
  input  logic [IW-1:0]       wr_pos,
  input  logic [DW-1:0]       wr_value,
  input  logic [DW-1:0]       load_words [DEPTH],
  output logic [DW-1:0]       words [DEPTH]
);

  // Chain the cells; the last one wraps back to the first
  for (genvar k = 0; k < DEPTH; k++) begin : g_cell
    localparam int Lft = (k + DEPTH - 1) % DEPTH;
    localparam int Rgt = (k + 1) % DEPTH;

    clle_cell #(
      .DW (DW),
      .IW (IW),
      .IDX(k)
    ) u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .lo         (lo),
      .hi         (hi),
      .wr_pos     (wr_pos),
      .wr_value   (wr_value),
      .load_value (load_words[k]),
      .left_value (words[Lft]),
      .right_value(words[Rgt]),
      .value      (words[k])
    );
  end

endmodule

// ----- rtl/cursor_linked_list_engine.sv -----
// Top level of the cursor linked list engine: control, three cell rows, result register.
//
//   channel  dir  handshake          payload
//   s_*      in   s_tvalid/s_tready  tuser = func, tdata = data_value
//   m_*      out  m_tvalid/m_tready  tdata = status .. cursor_value
//
// Each request has two steps: the first updates the three cell rows (front-aligned,
// back-aligned and cursor-centered ring), the second registers the result from their head cells.
// A request is taken while the previous result still waits in the output register;
// the result step then waits until that register is free.
// Reset (rst, synchronous) empties the list and drops the cursor; cell contents are
// left as they are, since nothing past the list length is ever shown.
module cursor_linked_list_engine #(
  parameter  int POOL_DEPTH = 256,
  parameter  int DATA_WIDTH = 32,
  localparam int DW         = DATA_WIDTH,
  localparam int IW         = $clog2(POOL_DEPTH),
  localparam int CW         = $clog2(POOL_DEPTH + 1),
  localparam int InW        = ((DW + 7) / 8) * 8,
  localparam int OutBits    = 2 + CW + (IW + 1) + 3 * DW,
  localparam int OutW       = ((OutBits + 7) / 8) * 8
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  // data_value
  input  logic [InW-1:0]      s_tdata,
  // func
  input  logic [3:0]          s_tuser,
  output logic                m_tvalid,
  input  logic                m_tready,
  // status, list_length, cursor_position, front_value, back_value, cursor_value
  output logic [OutW-1:0]     m_tdata
);

  localparam logic [IW-1:0] Last = IW'(POOL_DEPTH - 1);
  localparam logic [IW-1:0] One  = IW'(1);
  localparam logic [CW-1:0] Full = CW'(POOL_DEPTH);

  typedef enum logic [1:0] {
    S_TAKE = 2'b01,
    S_FORM = 2'b10
  } state_t;

  state_t              state, state_next;
  logic [CW-1:0]       count, count_next;
  logic                cur_valid, cur_valid_next;
  logic [IW-1:0]       cur_idx, cur_idx_next;
  clle_pkg::status_t   st_q, st_next;

  clle_pkg::func_t     func;
  logic [DW-1:0]       data_value;
  logic                take;
  logic                empty, full;
  logic [IW-1:0]       n_pos, nm1, cp1, dm1c, n_c, nm1_c;

  clle_pkg::row_ctl_t  f_ctl, b_ctl, c_ctl;
  logic [IW-1:0]       f_lo, f_hi, f_wp;
  logic [IW-1:0]       b_lo, b_hi, b_wp;
  logic [IW-1:0]       c_lo, c_hi, c_wp;
  logic                load_from_back;

  logic [DW-1:0]       front_words [POOL_DEPTH];
  logic [DW-1:0]       back_words  [POOL_DEPTH];
  logic [DW-1:0]       cur_words   [POOL_DEPTH];
  logic [DW-1:0]       cur_load    [POOL_DEPTH];
  logic [DW-1:0]       no_load     [POOL_DEPTH];

  logic                load_out;
  logic [IW:0]         cursor_position;
  logic [DW-1:0]       front_value, back_value, cursor_value;

  assign func       = clle_pkg::func_t'(s_tuser);
  assign data_value = s_tdata[DW-1:0];
  assign s_tready   = (state == S_TAKE);
  assign take       = s_tvalid && s_tready;

  // Positions in the three rows
  assign empty = (count == '0);
  assign full  = (count == Full);
  assign n_pos = count[IW-1:0];
  assign nm1   = IW'(count - CW'(1));
  assign cp1   = cur_idx + One;
  assign dm1c  = Last - cur_idx;
  assign n_c   = n_pos - cur_idx;
  assign nm1_c = nm1 - cur_idx;

  // Decode the request: status, new length and cursor, and a command per row
  always_comb begin
    st_next        = clle_pkg::STAT_OK;
    count_next     = count;
    cur_valid_next = cur_valid;
    cur_idx_next   = cur_idx;
    f_ctl          = '0;
    b_ctl          = '0;
    c_ctl          = '0;
    f_lo           = '0;
    f_hi           = '0;
    f_wp           = '0;
    b_lo           = '0;
    b_hi           = '0;
    b_wp           = '0;
    c_lo           = '0;
    c_hi           = '0;
    c_wp           = '0;
    load_from_back = 1'b0;

    unique case (func)
      clle_pkg::FN_PREPEND: begin
        if (full) begin
          st_next = clle_pkg::STAT_FULL;
        end else begin
          count_next     = count + CW'(1);
          cur_idx_next   = cur_valid ? cp1 : cur_idx;
          f_ctl.shift_up = 1'b1;
          f_hi           = n_pos;
          f_ctl.wr_en    = 1'b1;
          b_ctl.wr_en    = 1'b1;
          b_wp           = n_pos;
          c_ctl.wr_en    = cur_valid;
          c_wp           = dm1c;
        end
      end
      clle_pkg::FN_APPEND: begin
        if (full) begin
          st_next = clle_pkg::STAT_FULL;
        end else begin
          count_next     = count + CW'(1);
          f_ctl.wr_en    = 1'b1;
          f_wp           = n_pos;
          b_ctl.shift_up = 1'b1;
          b_hi           = n_pos;
          b_ctl.wr_en    = 1'b1;
          c_ctl.wr_en    = cur_valid;
          c_wp           = n_c;
        end
      end
      clle_pkg::FN_INS_BEFORE: begin
        if (empty) begin
          st_next = clle_pkg::STAT_EMPTY;
        end else if (!cur_valid) begin
          st_next = clle_pkg::STAT_NO_CURSOR;
        end else if (full) begin
          st_next = clle_pkg::STAT_FULL;
        end else begin
          count_next       = count + CW'(1);
          cur_idx_next     = cp1;
          f_ctl.shift_up   = 1'b1;
          f_lo             = cur_idx;
          f_hi             = n_pos;
          f_ctl.wr_en      = 1'b1;
          f_wp             = cur_idx;
          b_ctl.shift_up   = 1'b1;
          b_lo             = n_c;
          b_hi             = n_pos;
          b_ctl.wr_en      = 1'b1;
          b_wp             = n_c;
          c_ctl.shift_down = 1'b1;
          c_lo             = dm1c;
          c_hi             = Last;
          c_ctl.wr_en      = 1'b1;
          c_wp             = Last;
        end
      end
      clle_pkg::FN_INS_AFTER: begin
        if (empty) begin
          st_next = clle_pkg::STAT_EMPTY;
        end else if (!cur_valid) begin
          st_next = clle_pkg::STAT_NO_CURSOR;
        end else if (full) begin
          st_next = clle_pkg::STAT_FULL;
        end else begin
          count_next     = count + CW'(1);
          f_ctl.shift_up = 1'b1;
          f_lo           = cp1;
          f_hi           = n_pos;
          f_ctl.wr_en    = 1'b1;
          f_wp           = cp1;
          b_ctl.shift_up = 1'b1;
          b_lo           = nm1_c;
          b_hi           = n_pos;
          b_ctl.wr_en    = 1'b1;
          b_wp           = nm1_c;
          c_ctl.shift_up = 1'b1;
          c_lo           = One;
          c_hi           = n_c;
          c_ctl.wr_en    = 1'b1;
          c_wp           = One;
        end
      end
      clle_pkg::FN_DEL_FRONT: begin
        if (empty) begin
          st_next = clle_pkg::STAT_EMPTY;
        end else begin
          count_next = count - CW'(1);
          if (cur_valid && (cur_idx == '0)) begin
            cur_valid_next = 1'b0;
          end else if (cur_valid) begin
            cur_idx_next = cur_idx - One;
          end
          f_ctl.shift_down = 1'b1;
          f_hi             = nm1;
        end
      end
      clle_pkg::FN_DEL_BACK: begin
        if (empty) begin
          st_next = clle_pkg::STAT_EMPTY;
        end else begin
          count_next = count - CW'(1);
          if (cur_valid && (cur_idx == nm1)) begin
            cur_valid_next = 1'b0;
          end
          b_ctl.shift_down = 1'b1;
          b_hi             = nm1;
        end
      end
      clle_pkg::FN_DEL_CURSOR: begin
        if (empty) begin
          st_next = clle_pkg::STAT_EMPTY;
        end else if (!cur_valid) begin
          st_next = clle_pkg::STAT_NO_CURSOR;
        end else begin
          count_next       = count - CW'(1);
          cur_valid_next   = 1'b0;
          f_ctl.shift_down = 1'b1;
          f_lo             = cur_idx;
          f_hi             = nm1;
          b_ctl.shift_down = 1'b1;
          b_lo             = nm1_c;
          b_hi             = nm1;
        end
      end
      clle_pkg::FN_SET: begin
        if (empty) begin
          st_next = clle_pkg::STAT_EMPTY;
        end else if (!cur_valid) begin
          st_next = clle_pkg::STAT_NO_CURSOR;
        end else begin
          f_ctl.wr_en = 1'b1;
          f_wp        = cur_idx;
          b_ctl.wr_en = 1'b1;
          b_wp        = nm1_c;
          c_ctl.wr_en = 1'b1;
        end
      end
      clle_pkg::FN_MV_FRONT: begin
        if (!empty) begin
          cur_valid_next = 1'b1;
          cur_idx_next   = '0;
          c_ctl.load     = 1'b1;
        end
      end
      clle_pkg::FN_MV_BACK: begin
        if (!empty) begin
          cur_valid_next = 1'b1;
          cur_idx_next   = nm1;
          c_ctl.load     = 1'b1;
          load_from_back = 1'b1;
        end
      end
      clle_pkg::FN_MV_PREV: begin
        if (!cur_valid) begin
          st_next = clle_pkg::STAT_NO_CURSOR;
        end else if (cur_idx == '0) begin
          cur_valid_next = 1'b0;
        end else begin
          cur_idx_next = cur_idx - One;
          c_ctl.rot_up = 1'b1;
        end
      end
      clle_pkg::FN_MV_NEXT: begin
        if (!cur_valid) begin
          st_next = clle_pkg::STAT_NO_CURSOR;
        end else if (cur_idx == nm1) begin
          cur_valid_next = 1'b0;
        end else begin
          cur_idx_next   = cp1;
          c_ctl.rot_down = 1'b1;
        end
      end
      clle_pkg::FN_CLEAR: begin
        count_next     = '0;
        cur_valid_next = 1'b0;
      end
      default: begin
      end
    endcase

    // Rows hold unless a request is taken this cycle
    if (!take) begin
      f_ctl = '0;
      b_ctl = '0;
      c_ctl = '0;
    end
  end

  // Cursor ring reloads from the front row, or the back row read backward around the ring
  assign no_load = '{default: '0};

  for (genvar k = 0; k < POOL_DEPTH; k++) begin : g_cur_load
    localparam int Src = (POOL_DEPTH - k) % POOL_DEPTH;
    assign cur_load[k] = load_from_back ? back_words[Src] : front_words[k];
  end

  clle_row #(
    .DEPTH(POOL_DEPTH),
    .DW   (DW),
    .IW   (IW)
  ) u_front (
    .clk       (clk),
    .ctl       (f_ctl),
    .lo        (f_lo),
    .hi        (f_hi),
    .wr_pos    (f_wp),
    .wr_value  (data_value),
    .load_words(no_load),
    .words     (front_words)
  );

  clle_row #(
    .DEPTH(POOL_DEPTH),
    .DW   (DW),
    .IW   (IW)
  ) u_back (
    .clk       (clk),
    .ctl       (b_ctl),
    .lo        (b_lo),
    .hi        (b_hi),
    .wr_pos    (b_wp),
    .wr_value  (data_value),
    .load_words(no_load),
    .words     (back_words)
  );

  clle_row #(
    .DEPTH(POOL_DEPTH),
    .DW   (DW),
    .IW   (IW)
  ) u_cur (
    .clk       (clk),
    .ctl       (c_ctl),
    .lo        (c_lo),
    .hi        (c_hi),
    .wr_pos    (c_wp),
    .wr_value  (data_value),
    .load_words(cur_load),
    .words     (cur_words)
  );

  // Sequence: take a request, then register its result
  always_comb begin
    unique case (state)
      S_TAKE:  state_next = take ? S_FORM : S_TAKE;
      S_FORM:  state_next = load_out ? S_TAKE : S_FORM;
      default: state_next = S_TAKE;
    endcase
  end

  // Update list length and cursor on each taken request
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_TAKE;
      count     <= '0;
      cur_valid <= 1'b0;
      cur_idx   <= '0;
    end else begin
      state <= state_next;
      if (take) begin
        count     <= count_next;
        cur_valid <= cur_valid_next;
        cur_idx   <= cur_idx_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      st_q <= st_next;
    end
  end

  // Result fields from the head cells
  assign load_out        = (state == S_FORM) && (!m_tvalid || m_tready);
  assign cursor_position = cur_valid ? {1'b0, cur_idx} : '1;
  assign front_value     = empty ? '0 : front_words[0];
  assign back_value      = empty ? '0 : back_words[0];
  assign cursor_value    = cur_valid ? cur_words[0] : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load_out) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      m_tdata <= OutW'({cursor_value, back_value, front_value, cursor_position, count,
                        st_q});
    end
  end

  // Checks
  a_take_form: assert property (@(posedge clk) disable iff (rst)
    take |=> (state == S_FORM))
    else $error("request taken but no result step follows");

  a_cursor_in_list: assert property (@(posedge clk) disable iff (rst)
    cur_valid |-> (CW'(cur_idx) < count))
    else $error("cursor index beyond list length");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= Full)
    else $error("list length beyond pool depth");

  a_error_holds: assert property (@(posedge clk) disable iff (rst)
    (take && (st_next != clle_pkg::STAT_OK)) |=>
      ($stable(count) && $stable(cur_valid) && $stable(cur_idx)))
    else $error("failed request changed the list");

  a_clear_empties: assert property (@(posedge clk) disable iff (rst)
    (take && (func == clle_pkg::FN_CLEAR)) |=> ((count == '0) && !cur_valid))
    else $error("clear left elements or a cursor");

endmodule
